// ===== hw/rtl/html_entity_decoder_defines.svh =====
// Assertion macros for the entity decoder modules
`ifndef HTML_ENTITY_DECODER_DEFINES_SVH
`define HTML_ENTITY_DECODER_DEFINES_SVH

// Clocked check, held off while in reset
`define HED_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define HED_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/hed_pkg.sv =====
// Types, constants and trie tables of the entity decoder
package hed_pkg;

	localparam int unsigned NodeW     = 5;
	localparam int unsigned LenW      = 3;
	localparam int unsigned PathW     = 64;
	localparam int unsigned FifoDepth = 4;
	localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
	localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

	localparam logic [NodeW-1:0] NodeIdle = 5'd0;
	localparam logic [NodeW-1:0] NodeAmp  = 5'd1;
	localparam logic [NodeW-1:0] NodeLast = 5'd20;

	localparam logic [7:0] ChAmp  = 8'h26;
	localparam logic [7:0] ChSemi = 8'h3B;

	typedef struct packed {
		logic [NodeW-1:0] node_a;
		logic             chr_vld;
		logic [7:0]       chr;
		logic [NodeW-1:0] node_b;
		logic             last;
	} hed_entry_t;

	function automatic logic [NodeW-1:0] next_node(input logic [NodeW-1:0] cur,
		input logic [7:0] c);
		logic [NodeW-1:0] nx;
		nx = NodeIdle;
		unique case (cur)
			5'd0:  if (c == ChAmp) nx = NodeAmp;
			5'd1: begin
				if (c == "q") nx = 5'd2;
				else if (c == "a") nx = 5'd6;
				else if (c == "g") nx = 5'd12;
				else if (c == "l") nx = 5'd14;
				else if (c == "f") nx = 5'd16;
			end
			5'd2:  if (c == "u") nx = 5'd3;
			5'd3:  if (c == "o") nx = 5'd4;
			5'd4:  if (c == "t") nx = 5'd5;
			5'd6: begin
				if (c == "p") nx = 5'd7;
				else if (c == "m") nx = 5'd10;
			end
			5'd7:  if (c == "o") nx = 5'd8;
			5'd8:  if (c == "s") nx = 5'd9;
			5'd10: if (c == "p") nx = 5'd11;
			5'd12: if (c == "t") nx = 5'd13;
			5'd14: if (c == "t") nx = 5'd15;
			5'd16: if (c == "r") nx = 5'd17;
			5'd17: if (c == "a") nx = 5'd18;
			5'd18: if (c == "s") nx = 5'd19;
			5'd19: if (c == "l") nx = 5'd20;
			default: nx = NodeIdle;
		endcase
		return nx;
	endfunction

	function automatic logic [7:0] node_result(input logic [NodeW-1:0] n);
		logic [7:0] r;
		unique case (n)
			5'd5:    r = 8'h22;
			5'd9:    r = 8'h27;
			5'd11:   r = 8'h26;
			5'd13:   r = 8'h3E;
			5'd15:   r = 8'h3C;
			5'd20:   r = 8'h2F;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [LenW-1:0] node_len(input logic [NodeW-1:0] n);
		logic [LenW-1:0] l;
		unique case (n)
			5'd1:                                 l = 3'd1;
			5'd2, 5'd6, 5'd12, 5'd14, 5'd16:      l = 3'd2;
			5'd3, 5'd7, 5'd10, 5'd13, 5'd15, 5'd17: l = 3'd3;
			5'd4, 5'd8, 5'd11, 5'd18:             l = 3'd4;
			5'd5, 5'd9, 5'd19:                    l = 3'd5;
			5'd20:                                l = 3'd6;
			default:                              l = 3'd0;
		endcase
		return l;
	endfunction

	// First character in the low byte
	function automatic logic [PathW-1:0] node_path(input logic [NodeW-1:0] n);
		logic [PathW-1:0] p;
		unique case (n)
			5'd1:    p = {56'h0, "&"};
			5'd2:    p = {48'h0, "q&"};
			5'd3:    p = {40'h0, "uq&"};
			5'd4:    p = {32'h0, "ouq&"};
			5'd5:    p = {24'h0, "touq&"};
			5'd6:    p = {48'h0, "a&"};
			5'd7:    p = {40'h0, "pa&"};
			5'd8:    p = {32'h0, "opa&"};
			5'd9:    p = {24'h0, "sopa&"};
			5'd10:   p = {40'h0, "ma&"};
			5'd11:   p = {32'h0, "pma&"};
			5'd12:   p = {48'h0, "g&"};
			5'd13:   p = {40'h0, "tg&"};
			5'd14:   p = {48'h0, "l&"};
			5'd15:   p = {40'h0, "tl&"};
			5'd16:   p = {48'h0, "f&"};
			5'd17:   p = {40'h0, "rf&"};
			5'd18:   p = {32'h0, "arf&"};
			5'd19:   p = {24'h0, "sarf&"};
			5'd20:   p = {16'h0, "lsarf&"};
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

// ===== hw/rtl/html_entity_decoder.sv =====
// Top level of the HTML entity decoder
// Decodes &quot; &apos; &amp; &gt; &lt; and &frasl; in a byte stream; any
// other text, including broken or unfinished entities, passes through
// unchanged, and out_last marks the final decoded byte once in_last is seen.
// A byte is taken every cycle while the four-entry burst queue has room;
// the output side sends one byte per cycle while out_ready allows, so a byte
// that releases a held prefix of n bytes sends up to n + 1 bytes (at most 7),
// while bytes that extend a prefix send nothing. An accepted byte reaches the
// output through the burst queue and then the output register.
module html_entity_decoder import hed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);

	hed_entry_t wr_entry;
	hed_entry_t head;
	logic       push;
	logic       pop;
	logic       full;
	logic       empty;
	logic       accept;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	hed_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (in_byte),
		.in_last (in_last),
		.push    (push),
		.entry   (wr_entry)
	);

	hed_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_entry),
		.pop     (pop),
		.rd_data (head),
		.full    (full),
		.empty   (empty)
	);

	hed_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

// ===== hw/rtl/hed_front.sv =====
// Front end: tracks the pending entity prefix and classifies each byte
module hed_front import hed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       push,
	output hed_entry_t entry
);

	logic [NodeW-1:0] match_node_q;
	logic [NodeW-1:0] cur;
	logic [NodeW-1:0] child;
	logic [NodeW-1:0] nxt;
	logic [7:0]       res;

	always_comb begin
		cur   = (match_node_q > NodeLast) ? NodeIdle : match_node_q;
		res   = node_result(cur);
		child = next_node(cur, in_byte);
		entry = '0;
		nxt   = NodeIdle;
		if (cur != NodeIdle && in_byte == ChSemi && res != 8'h00) begin
			entry.chr_vld = 1'b1;
			entry.chr     = res;
		end else if (child != NodeIdle) begin
			nxt = child;
		end else begin
			entry.node_a = cur;
			if (in_byte == ChAmp) begin
				nxt = NodeAmp;
			end else begin
				entry.chr_vld = 1'b1;
				entry.chr     = in_byte;
			end
		end
		entry.last = in_last;
		if (in_last) begin
			entry.node_b = nxt;
			nxt          = NodeIdle;
		end
		push = accept && (entry.node_a != NodeIdle || entry.chr_vld ||
			entry.node_b != NodeIdle);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_node_q <= NodeIdle;
		end else if (accept) begin
			match_node_q <= nxt;
		end
	end

endmodule

// ===== hw/rtl/hed_fifo.sv =====
// Short queue of classified bursts between front and back
module hed_fifo import hed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  hed_entry_t wr_data,
	input  logic       pop,
	output hed_entry_t rd_data,
	output logic       full,
	output logic       empty
);

	hed_entry_t          mem_q [FifoDepth];
	logic [FifoPtrW-1:0] wr_ptr_q;
	logic [FifoPtrW-1:0] rd_ptr_q;
	logic [FifoCntW-1:0] count_q;

	assign full    = (count_q == FifoCntW'(FifoDepth));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/hed_back.sv =====
// Back end: expands each queued burst into output bytes, one per cycle while the output is not stalled
`include "html_entity_decoder_defines.svh"

module hed_back import hed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  hed_entry_t head,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic [LenW-1:0]  pos_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;
	logic [LenW-1:0]  len_a;
	logic [LenW-1:0]  len_b;
	logic [LenW:0]    total;
	logic [LenW:0]    pos_w;
	logic [LenW-1:0]  pos_b;
	logic [PathW-1:0] path_a;
	logic [PathW-1:0] path_b;
	logic [7:0]       chr;
	logic             is_end;
	logic             fire;

	always_comb begin
		len_a  = node_len(head.node_a);
		len_b  = node_len(head.node_b);
		path_a = node_path(head.node_a);
		path_b = node_path(head.node_b);
		total  = {1'b0, len_a} + {{LenW{1'b0}}, head.chr_vld} + {1'b0, len_b};
		pos_w  = {1'b0, pos_q};
		pos_b  = LenW'(pos_w - {1'b0, len_a} - {{LenW{1'b0}}, head.chr_vld});
		if (pos_w < {1'b0, len_a}) begin
			chr = path_a[{pos_q, 3'b000} +: 8];
		end else if (head.chr_vld && pos_w == {1'b0, len_a}) begin
			chr = head.chr;
		end else begin
			chr = path_b[{pos_b, 3'b000} +: 8];
		end
		is_end = (pos_w == total - 1'b1);
		fire   = !empty && (!out_valid_q || out_ready);
		pop    = fire && is_end;
	end

	// advance through the burst, hold while the output stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				pos_q       <= is_end ? '0 : pos_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q <= chr;
			out_last_q <= head.last && is_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	`HED_ASSERT(a_idle_pos, empty |-> pos_q == '0, "burst position not cleared when queue empty")
	`HED_ASSERT(a_burst_nonempty, !empty |-> total != '0, "queued burst carries no bytes")
	`HED_ASSERT(a_pos_in_range, !empty |-> pos_w < total, "burst position beyond burst length")

endmodule
